// ===== rtl/life_row_stencil_step_macros.svh =====
// Assertion macros for the top RTL file of the row stencil block.
`ifndef LIFE_ROW_STENCIL_STEP_MACROS_SVH
`define LIFE_ROW_STENCIL_STEP_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold on the cycle after the antecedent.
`define LRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define LRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define LRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define LRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/lrs_pkg.sv =====
package lrs_pkg;

	localparam int GRID_W  = 7;
	localparam int FIELD_W = 64;
	localparam logic [GRID_W-1:0] GRID_WIDTH_RESET = 7'd64;

	// B3/S23 neighbor counts.
	localparam logic [3:0] LIFE_SURVIVE = 4'd2;
	localparam logic [3:0] LIFE_BIRTH   = 4'd3;

	// Results written into the output queue by one input transaction.
	typedef struct packed {
		logic push_a;	// result for the pending row
		logic push_b;	// result for the bottom row
	} lrs_push_t;

endpackage

// ===== rtl/life_row_stencil_step.sv =====
// One Game of Life generation (B3/S23) over a board streamed one row per
// transaction, top row first, with dead cells beyond every edge.
// Input channel s_*: tdata holds a row, bit i is column i; tlast marks the
// bottom row. Output channel m_*: tdata holds the next generation of a row
// and the mask of cells that changed; tlast marks the bottom row's result.
// The first row of a board gives no result unless it is the bottom row.
// Each later row gives the result for the row above it, and the bottom row
// also gives its own result, so a board of N rows yields N results in order.
// A result enters the output queue at the edge that accepts the row that
// completes it and is presented once the results ahead of it have left.
// Throughput is one row per cycle while s_tready is high. A bottom row puts
// two results into the queue; a four-entry queue absorbs this and s_tready
// drops only when the queue holds more than two.
// When m_tready is low, results wait in the queue and input continues until
// it fills. cfg_we writes the number of columns in use; columns at or above
// it read as dead and come out as zero.
// Reset clears the row window and the queue and sets the width to 64.
`include "life_row_stencil_step_macros.svh"

module life_row_stencil_step #(
	parameter int WIDTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,	// row_cells[63:0]
	input  logic         s_tlast,	// last_row
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,	// next_row[63:0], changed_cells[127:64]
	output logic         m_tlast,	// board_done
	input  logic         cfg_we,
	input  logic [6:0]   cfg_data
);

	localparam int ENTRY_W = 2 * WIDTH + 1;

	logic [lrs_pkg::GRID_W-1:0] grid_width_q;
	logic [WIDTH-1:0]           above_q;
	logic [WIDTH-1:0]           pend_q;
	logic                       pend_vld_q;

	logic [WIDTH-1:0]   col_en;
	logic [WIDTH-1:0]   row_in;
	logic [WIDTH-1:0]   above_m;
	logic [WIDTH-1:0]   pend_m;
	logic [WIDTH-1:0]   prev_m;
	logic [WIDTH+1:0]   above_pad;
	logic [WIDTH+1:0]   pend_pad;
	logic [WIDTH+1:0]   prev_pad;
	logic [WIDTH+1:0]   row_pad;
	logic [WIDTH-1:0]   nxt_a;
	logic [WIDTH-1:0]   chg_a;
	logic [WIDTH-1:0]   nxt_b;
	logic [WIDTH-1:0]   chg_b;
	logic [ENTRY_W-1:0] entry_a;
	logic [ENTRY_W-1:0] entry_b;
	logic [ENTRY_W-1:0] head;
	logic               in_acc;
	logic               has_room;
	lrs_pkg::lrs_push_t push;

	genvar gi;
	generate
		for (gi = 0; gi < WIDTH; gi++) begin : g_col
			assign col_en[gi] = grid_width_q > lrs_pkg::GRID_W'(gi);
		end
	endgenerate

	assign row_in  = s_tdata[WIDTH-1:0] & col_en;
	assign above_m = above_q & col_en;
	assign pend_m  = pend_q & col_en;
	assign prev_m  = pend_vld_q ? pend_m : '0;

	// Dead cells pad both board edges.
	assign above_pad = {1'b0, above_m, 1'b0};
	assign pend_pad  = {1'b0, pend_m, 1'b0};
	assign prev_pad  = {1'b0, prev_m, 1'b0};
	assign row_pad   = {1'b0, row_in, 1'b0};

	// Lane set A finishes the pending row, lane set B the bottom row.
	generate
		for (gi = 0; gi < WIDTH; gi++) begin : g_lane
			lrs_cell u_cell_a (
				.up_col  (above_pad[gi+2:gi]),
				.cur_col (pend_pad[gi+2:gi]),
				.dn_col  (row_pad[gi+2:gi]),
				.en      (col_en[gi]),
				.nxt     (nxt_a[gi]),
				.chg     (chg_a[gi])
			);
			lrs_cell u_cell_b (
				.up_col  (prev_pad[gi+2:gi]),
				.cur_col (row_pad[gi+2:gi]),
				.dn_col  (3'b000),
				.en      (col_en[gi]),
				.nxt     (nxt_b[gi]),
				.chg     (chg_b[gi])
			);
		end
	endgenerate

	// Merge the lane outputs into queue entries.
	assign entry_a = {1'b0, chg_a, nxt_a};
	assign entry_b = {1'b1, chg_b, nxt_b};

	assign s_tready    = has_room;
	assign in_acc      = s_tvalid & has_room;
	assign push.push_a = in_acc & pend_vld_q;
	assign push.push_b = in_acc & s_tlast;

	lrs_res_fifo #(
		.DATA_W (ENTRY_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_a    (entry_a),
		.data_b    (entry_b),
		.pop       (m_tready),
		.has_room  (has_room),
		.not_empty (m_tvalid),
		.head      (head)
	);

	assign m_tdata[63:0]   = lrs_pkg::FIELD_W'(head[WIDTH-1:0]);
	assign m_tdata[127:64] = lrs_pkg::FIELD_W'(head[2*WIDTH-1:WIDTH]);
	assign m_tlast         = head[2*WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= lrs_pkg::GRID_WIDTH_RESET;
		end else if (cfg_we) begin
			grid_width_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q    <= '0;
			pend_q     <= '0;
			pend_vld_q <= 1'b0;
		end else if (in_acc) begin
			if (s_tlast) begin
				above_q    <= '0;
				pend_q     <= '0;
				pend_vld_q <= 1'b0;
			end else begin
				// Stored rows are masked on acceptance; the current width masks them again on use.
				above_q    <= pend_vld_q ? pend_q : '0;
				pend_q     <= row_in;
				pend_vld_q <= 1'b1;
			end
		end
	end

	`LRS_ASSERT_NEXT(a_pend_set, clk, arst_n, in_acc && !s_tlast, pend_vld_q, "row not held as pending")
	`LRS_ASSERT_NEXT(a_pend_clr, clk, arst_n, in_acc && s_tlast, !pend_vld_q, "window not cleared after bottom row")
	`LRS_ASSERT_NEXT(a_result_out, clk, arst_n, in_acc && (pend_vld_q || s_tlast), m_tvalid, "result missing after transaction")
	`LRS_ASSERT_NOW(a_room_two, clk, arst_n, push.push_b && !pend_vld_q, !push.push_a, "pushed result for absent pending row")

endmodule

// ===== rtl/lrs_cell.sv =====
module lrs_cell (
	input  logic [2:0] up_col,
	input  logic [2:0] cur_col,
	input  logic [2:0] dn_col,
	input  logic       en,
	output logic       nxt,
	output logic       chg
);

	logic [3:0] nbr_cnt;
	logic       alive;

	// Bit 1 of each window is this column; bits 0 and 2 are its neighbors.
	assign nbr_cnt = 4'(up_col[0]) + 4'(up_col[1]) + 4'(up_col[2])
		+ 4'(cur_col[0]) + 4'(cur_col[2])
		+ 4'(dn_col[0]) + 4'(dn_col[1]) + 4'(dn_col[2]);

	always_comb begin
		if (cur_col[1]) begin
			alive = (nbr_cnt == lrs_pkg::LIFE_SURVIVE) || (nbr_cnt == lrs_pkg::LIFE_BIRTH);
		end else begin
			alive = (nbr_cnt == lrs_pkg::LIFE_BIRTH);
		end
	end

	assign nxt = en & alive;
	assign chg = en & (alive ^ cur_col[1]);

endmodule

// ===== rtl/lrs_res_fifo.sv =====
module lrs_res_fifo #(
	parameter int DATA_W = 129
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lrs_pkg::lrs_push_t  push,
	input  logic [DATA_W-1:0]   data_a,
	input  logic [DATA_W-1:0]   data_b,
	input  logic                pop,
	output logic                has_room,
	output logic                not_empty,
	output logic [DATA_W-1:0]   head
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] fifo_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PTR_W-1:0]  wr_b_ptr;
	logic              do_pop;

	// Room for the two results a bottom row can bring, regardless of pops.
	assign has_room  = cnt_q <= CNT_W'(DEPTH - 2);
	assign not_empty = cnt_q != '0;
	assign head      = fifo_q[rd_ptr_q];
	assign do_pop    = pop & not_empty;
	assign wr_b_ptr  = wr_ptr_q + PTR_W'(push.push_a);

	always_ff @(posedge clk) begin
		if (push.push_a) begin
			fifo_q[wr_ptr_q] <= data_a;
		end
		if (push.push_b) begin
			fifo_q[wr_b_ptr] <= data_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.push_a) + PTR_W'(push.push_b);
			rd_ptr_q <= rd_ptr_q + PTR_W'(do_pop);
			cnt_q    <= cnt_q + CNT_W'(push.push_a) + CNT_W'(push.push_b) - CNT_W'(do_pop);
		end
	end

endmodule

// ===== sim/life_board_checker.sv =====
`timescale 1ns / 1ps

module life_board_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [63:0]                s_tdata,	// row_cells[63:0]
	input  logic                       s_tlast,	// last_row
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [127:0]               m_tdata,	// next_row[63:0], changed_cells[127:64]
	input  logic                       m_tlast,	// board_done
	input  logic                       cfg_we,
	input  logic [lrs_pkg::GRID_W-1:0] cfg_data,
	output int                         pending_results,
	output int                         fail_count
);

	typedef struct packed {
		logic [63:0] next_row;
		logic [63:0] changed_cells;
		logic        board_done;
	} gen_result_t;

	gen_result_t                gen_q[$];
	logic [lrs_pkg::GRID_W-1:0] col_width;
	logic [63:0]                prior_row;
	logic [63:0]                held_row;
	logic                       held_valid;
	int                         mismatches = 0;

	function automatic logic [63:0] width_mask(logic [lrs_pkg::GRID_W-1:0] w);
		if (w >= 64)
			return '1;
		return (64'd1 << w) - 64'd1;
	endfunction

	// Neighbors outside the board, and masked-off columns, count as dead.
	function automatic logic [63:0] next_gen(logic [63:0] up, logic [63:0] cur,
			logic [63:0] dn, logic [63:0] mask);
		logic [63:0] u;
		logic [63:0] c;
		logic [63:0] d;
		logic [63:0] res;
		int n;
		u = up & mask;
		c = cur & mask;
		d = dn & mask;
		res = '0;
		for (int i = 0; i < 64; i++) begin
			n = int'(u[i]) + int'(d[i]);
			if (i > 0)
				n += int'(u[i-1]) + int'(c[i-1]) + int'(d[i-1]);
			if (i < 63)
				n += int'(u[i+1]) + int'(c[i+1]) + int'(d[i+1]);
			res[i] = (n == int'(lrs_pkg::LIFE_BIRTH))
				|| (c[i] && n == int'(lrs_pkg::LIFE_SURVIVE));
		end
		return res & mask;
	endfunction

	function automatic gen_result_t row_result(logic [63:0] up, logic [63:0] cur,
			logic [63:0] dn, logic [63:0] mask, logic done);
		gen_result_t r;
		r.next_row = next_gen(up, cur, dn, mask);
		r.changed_cells = (r.next_row ^ cur) & mask;
		r.board_done = done;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] mask;
		logic [63:0] row;
		logic [63:0] prev;
		gen_result_t want;
		gen_result_t got;
		if (!arst_n) begin
			gen_q.delete();
			col_width = lrs_pkg::GRID_WIDTH_RESET;
			prior_row = '0;
			held_row = '0;
			held_valid = 1'b0;
			pending_results <= 0;
			fail_count <= mismatches;
		end else begin
			if (s_tvalid && s_tready) begin
				mask = width_mask(col_width);
				row = s_tdata & mask;
				prev = held_valid ? held_row : '0;
				if (held_valid)
					gen_q.push_back(row_result(prior_row, held_row, row, mask, 1'b0));
				if (s_tlast) begin
					gen_q.push_back(row_result(prev, row, '0, mask, 1'b1));
					prior_row = '0;
					held_row = '0;
					held_valid = 1'b0;
				end else begin
					prior_row = prev;
					held_row = row;
					held_valid = 1'b1;
				end
			end
			if (m_tvalid && m_tready) begin
				got.next_row = m_tdata[63:0];
				got.changed_cells = m_tdata[127:64];
				got.board_done = m_tlast;
				if (gen_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result: next %h changed %h done %b",
							$time, got.next_row, got.changed_cells, got.board_done);
					mismatches++;
				end else begin
					want = gen_q.pop_front();
					if (got.next_row !== want.next_row
							|| got.changed_cells !== want.changed_cells
							|| got.board_done !== want.board_done) begin
						if (mismatches < 10)
							$display({"%0t: result mismatch: expected next %h changed %h done %b,",
								" got next %h changed %h done %b"}, $time,
								want.next_row, want.changed_cells, want.board_done,
								got.next_row, got.changed_cells, got.board_done);
						mismatches++;
					end
				end
			end
			// A width write only affects rows accepted after this edge.
			if (cfg_we)
				col_width = cfg_data;
			pending_results <= gen_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

// ===== sim/tb_life_row_stencil_step.sv =====
`timescale 1ns / 1ps

module tb_life_row_stencil_step;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [63:0]                s_tdata = '0;	// row_cells[63:0]
	logic                       s_tlast = 1'b0;	// last_row
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [127:0]               m_tdata;	// next_row[63:0], changed_cells[127:64]
	logic                       m_tlast;	// board_done
	logic                       cfg_we = 1'b0;
	logic [lrs_pkg::GRID_W-1:0] cfg_data = '0;

	int pending_results;
	int fail_count;
	int rows_sent = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	int phase_width [10] = '{1, 63, 0, 127, 2, 64, 33, 100, 5, 64};

	always #4 clk = ~clk;

	life_row_stencil_step #(.WIDTH(64)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	life_board_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.pending_results (pending_results),
		.fail_count      (fail_count)
	);

	task automatic send_row(input logic [63:0] row, input logic last);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= row;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		rows_sent++;
	endtask

	// Wait until every result has left the block, then let it settle.
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_width(input logic [lrs_pkg::GRID_W-1:0] w);
		cfg_we <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] pick_row();
		logic [63:0] a;
		logic [63:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return a & b;
			4: return a | b;
			5: return 64'h7 << $urandom_range(0, 61);
			default: return a;
		endcase
	endfunction

	task automatic send_board(input int rows);
		for (int r = 0; r < rows; r++)
			send_row(pick_row(), r == rows - 1);
	endtask

	// Receiver side: random stall bursts, plus one long hold-off on request.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (150) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				stall = $urandom_range(1, 13);
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int phase_rows;
		int height;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed boards at the reset width.
		send_row('1, 1'b1);
		send_row('0, 1'b0);
		send_row('1, 1'b0);
		send_row('0, 1'b1);
		send_row(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		send_row(64'h5555_5555_5555_5555, 1'b0);
		send_row('1, 1'b1);
		// Vertical blinkers on both edge columns; the board must not wrap.
		send_row(64'h8000_0000_0000_0001, 1'b0);
		send_row(64'h8000_0000_0000_0001, 1'b0);
		send_row(64'h8000_0000_0000_0001, 1'b1);
		// Glider against the low edge, then one against the high edge.
		send_row(64'h2, 1'b0);
		send_row(64'h4, 1'b0);
		send_row(64'h7, 1'b0);
		send_row('0, 1'b1);
		send_row(64'h4000_0000_0000_0000, 1'b0);
		send_row(64'h8000_0000_0000_0000, 1'b0);
		send_row(64'he000_0000_0000_0000, 1'b1);
		wait_quiet();

		for (int p = 0; p < 10; p++) begin
			set_width(lrs_pkg::GRID_W'(phase_width[p]));
			if (p == 1)
				hold_req = 1'b1;
			phase_rows = 0;
			while (phase_rows < 130) begin
				if (rows_sent >= 1150)
					idle_on = 1'b0;
				height = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
					: $urandom_range(1, 8);
				send_board(height);
				phase_rows += height;
			end
			wait_quiet();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("tb_life_row_stencil_step: PASS");
		else
			$display("tb_life_row_stencil_step: FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_life_row_stencil_step: FAIL");
		$finish;
	end

endmodule
